/* hw/rtl/tf8rq_pkg.sv */
// ----------------------------------------------------------------------------
// Tapered float8 requantizer package
// Field widths and float constants shared by the requantizer modules.
// ----------------------------------------------------------------------------
package tf8rq_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned MantW = 23;

    typedef logic [WordW-1:0] word_t;
    typedef logic [ExpW-1:0]  exp_t;
    typedef logic [MantW-1:0] mant_t;

    localparam exp_t  ExpAllOnes = 8'hFF;
    localparam mant_t MantHalf   = 23'h400000;
    // Biased exponent thresholds (unbiased value + 127).
    localparam exp_t  ExpTopBand = 8'd138;  // e >= 11
    localparam exp_t  ExpK1High  = 8'd134;  // e >= 7
    localparam exp_t  ExpK2High  = 8'd131;  // e >= 4
    localparam exp_t  ExpK3      = 8'd123;  // e >= -4
    localparam exp_t  ExpK2Low   = 8'd120;  // e >= -7
    localparam exp_t  ExpK1Low   = 8'd116;  // e >= -11
    localparam exp_t  ExpOvf     = 8'd148;  // e > 21 overflows
    localparam exp_t  ExpUnf     = 8'd105;  // e < -22 underflows
endpackage

/* hw/rtl/tapered_float8_requantizer_core.sv */
// ----------------------------------------------------------------------------
// Tapered float8 requantizer core
// Rounds single-precision values to tapered 8-bit float precision.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the skid register is empty; its result
// is registered in the result register, or in the skid register on a stall.
// Rounding is a single add and mask, so throughput is one item per cycle when
// not stalled; the skid makes input ready depend only on registered state.
module tapered_float8_requantizer_core
    import tf8rq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  word_t value_bits,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t rounded_bits
);
    word_t res_comb;
    word_t out_reg, skid_reg;
    logic  out_v_reg, skid_v_reg;

    tf8rq_round u_round (.value_bits(value_bits), .rounded_bits(res_comb));

    assign in_ready     = !skid_v_reg;
    assign out_valid    = out_v_reg;
    assign rounded_bits = out_reg;

    // Control: result register with a one-entry skid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!out_v_reg || out_ready)
            begin
                out_v_reg  <= skid_v_reg || (in_valid && in_ready);
                skid_v_reg <= 1'b0;
            end
            else if (in_valid && in_ready)
                skid_v_reg <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ready)
            out_reg <= skid_v_reg ? skid_reg : res_comb;
        else if (in_valid && in_ready)
            skid_reg <= res_comb;
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg) else $error("skid full with empty output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rounded_bits))
        else $error("result changed while stalled");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid) else $error("accepted item lost");
`endif
endmodule

/* hw/rtl/tf8rq_round.sv */
// ----------------------------------------------------------------------------
// Tapered float8 rounding datapath
// Combinational rounding of one single-precision pattern to tapered precision.
// ----------------------------------------------------------------------------
module tf8rq_round
    import tf8rq_pkg::*;
(
    input  word_t value_bits,
    output word_t rounded_bits
);
    logic        sign;
    exp_t        ex;
    mant_t       mant;
    logic [1:0]  k;
    logic [23:0] sum;
    mant_t       keep;
    mant_t       half;
    logic        odd;
    exp_t        ex_r;
    mant_t       m_r;

    assign sign = value_bits[31];
    assign ex   = value_bits[30:23];
    assign mant = value_bits[22:0];

    // Kept mantissa bits from the exponent band.
    always_comb
    begin
        priority if (ex >= ExpTopBand) k = 2'd0;
        else if (ex >= ExpK1High)      k = 2'd1;
        else if (ex >= ExpK2High)      k = 2'd2;
        else if (ex >= ExpK3)          k = 2'd3;
        else if (ex >= ExpK2Low)       k = 2'd2;
        else if (ex >= ExpK1Low)       k = 2'd1;
        else                           k = 2'd0;
    end

    // Round to nearest, ties to even; with no kept bits a tie rounds up.
    always_comb
    begin
        unique case (k)
            2'd0:
            begin
                keep = 23'h000000; half = MantHalf; odd = 1'b1;
            end
            2'd1:
            begin
                keep = 23'h400000; half = 23'h200000; odd = mant[22];
            end
            2'd2:
            begin
                keep = 23'h600000; half = 23'h100000; odd = mant[21];
            end
            default:
            begin
                keep = 23'h700000; half = 23'h080000; odd = mant[20];
            end
        endcase
        sum  = {1'b0, mant} + {1'b0, half} - 24'd1 + {23'd0, odd};
        ex_r = ex + {7'd0, sum[23]};
        m_r  = sum[23] ? '0 : (sum[22:0] & keep);
    end

    // Special cases, then packing.
    always_comb
    begin
        priority if (ex == ExpAllOnes)
            rounded_bits = value_bits;
        else if (k == 2'd0 && ex >= ExpTopBand && ex_r > ExpOvf)
            rounded_bits = {sign, ExpAllOnes, 23'd0};
        else if (k == 2'd0 && ex < ExpTopBand && ex_r < ExpUnf)
            rounded_bits = '0;
        else
            rounded_bits = {sign, ex_r, m_r};
    end
endmodule
